[design/sha1_pkg.sv]
// Shared constants, types and round functions for the SHA-1 digest block.
package sha1_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned INDEX_W = 3;
  localparam int unsigned COUNT_W = 61;
  localparam int unsigned ROUNDS  = 80;
  localparam int unsigned DIGEST_WORDS = 5;

  typedef logic [WORD_W-1:0] word_t;

  localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h80;

  localparam word_t INIT_H0 = 32'h67452301;
  localparam word_t INIT_H1 = 32'hEFCDAB89;
  localparam word_t INIT_H2 = 32'h98BADCFE;
  localparam word_t INIT_H3 = 32'h10325476;
  localparam word_t INIT_H4 = 32'hC3D2E1F0;

  localparam word_t K_R0 = 32'h5A827999;
  localparam word_t K_R1 = 32'h6ED9EBA1;
  localparam word_t K_R2 = 32'h8F1BBCDC;
  localparam word_t K_R3 = 32'hCA62C1D6;

  function automatic word_t init_chain(input logic [INDEX_W-1:0] idx);
    word_t v;
    case (idx)
      3'd0:    v = INIT_H0;
      3'd1:    v = INIT_H1;
      3'd2:    v = INIT_H2;
      3'd3:    v = INIT_H3;
      default: v = INIT_H4;
    endcase
    return v;
  endfunction

  function automatic word_t round_const(input logic [6:0] rnd);
    word_t v;
    if (rnd < 7'd20) begin
      v = K_R0;
    end else if (rnd < 7'd40) begin
      v = K_R1;
    end else if (rnd < 7'd60) begin
      v = K_R2;
    end else begin
      v = K_R3;
    end
    return v;
  endfunction

  function automatic word_t round_func(input logic [6:0] rnd, input word_t b,
                                       input word_t c, input word_t d);
    word_t v;
    if (rnd < 7'd20) begin
      v = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      v = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      v = (b & c) | (b & d) | (c & d);
    end else begin
      v = b ^ c ^ d;
    end
    return v;
  endfunction

endpackage

[design/sha1_in_if.sv]
// Message byte channel: valid/ready handshake with one byte per request.
interface sha1_in_if
  import sha1_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              byte_present;
  logic              end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

[design/sha1_out_if.sv]
// Digest word channel: valid/ready handshake with one digest word per request.
interface sha1_out_if
  import sha1_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  digest_word;
  logic [INDEX_W-1:0] word_index;
  logic               last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

[design/sha1_message_digest.sv]
// SHA-1 digest engine: byte input, 16-word block memory, one round per cycle.
//
// msg carries one request per message byte (byte_present) and flags the final
// request with end_of_message; a request with neither flag changes nothing,
// and end_of_message without a byte closes the message at the bytes taken.
// digest returns five 32-bit words, index 0 first, last_word on index 4.
//
// Bytes are packed big-endian into a 16 x 32 block memory, one byte per cycle
// while the engine is idle. Each full block is read out of the memory into
// the schedule window, runs 80 rounds at one per cycle and is added into the
// chaining words; msg is held off meanwhile, so no new byte is taken until
// the block is done.
// Closing a message writes the pad and length words and compresses one or
// two more blocks; the digest then sits in an output buffer and the chaining
// state returns to the initial values, so the next message may start while
// the five words drain.
//
// rst is synchronous and clears the control state and chaining words; the
// block memory holds no reset value. If digest is stalled, bytes keep being
// taken, but a finished digest waits in DONE until the previous one has gone.
module sha1_message_digest
  import sha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  sha1_in_if.sink     msg,
  sha1_out_if.source  digest
);

  typedef enum logic [2:0] {
    IDLE, LOAD, ROUND, ADD, PAD_HEAD, PAD_FILL, DONE
  } state_t;

  state_t state;

  logic [WORD_W-1:0] block_mem [16];
  logic              mem_we;
  logic [3:0]        mem_waddr;
  word_t             mem_wdata;
  word_t             mem_rdata;

  word_t             chain [DIGEST_WORDS];
  word_t             obuf [DIGEST_WORDS];
  word_t             win [16];
  word_t             ra, rb, rc, rd, re;
  logic [23:0]       acc;
  logic [COUNT_W-1:0] byte_count;
  logic [6:0]        rnd;
  logic [4:0]        ld;
  logic [3:0]        pw;
  logic              fin, padding, pad_two, second;
  logic              out_busy;
  logic [INDEX_W-1:0] oidx;

  logic [5:0]  pos;
  logic [63:0] bit_len;
  logic        len_block;
  logic        msg_fire;
  word_t       head_word;
  word_t       fill_word;
  word_t       w_new;
  word_t       w_cur;
  word_t       t_sum;

  assign pos       = byte_count[5:0];
  assign bit_len   = {byte_count, 3'b000};
  assign len_block = !pad_two || second;
  assign msg.ready = (state == IDLE);
  assign msg_fire  = msg.valid && msg.ready;

  // pad word: earlier bytes of the partial word, then the 0x80 marker
  always_comb begin
    case (pos[1:0])
      2'd0:    head_word = {PAD_BYTE, 24'h0};
      2'd1:    head_word = {acc[23:16], PAD_BYTE, 16'h0};
      2'd2:    head_word = {acc[23:8], PAD_BYTE, 8'h0};
      default: head_word = {acc, PAD_BYTE};
    endcase
  end

  always_comb begin
    if (len_block && pw == 4'd14) begin
      fill_word = bit_len[63:32];
    end else if (len_block && pw == 4'd15) begin
      fill_word = bit_len[31:0];
    end else begin
      fill_word = '0;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos[5:2];
    mem_wdata = {acc, msg.data_byte};
    case (state)
      IDLE: begin
        mem_we = msg_fire && msg.byte_present && (pos[1:0] == 2'd3);
      end
      PAD_HEAD: begin
        mem_we    = 1'b1;
        mem_wdata = head_word;
      end
      PAD_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = pw;
        mem_wdata = fill_word;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      block_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= block_mem[ld[3:0]];
  end

  // schedule window: win[k] holds w[j-16+k] once j reaches 16
  assign w_new = {win[13][30:0] ^ win[8][30:0] ^ win[2][30:0] ^ win[0][30:0],
                  win[13][31] ^ win[8][31] ^ win[2][31] ^ win[0][31]};
  assign w_cur = (rnd < 7'd16) ? win[0] : w_new;
  assign t_sum = {ra[26:0], ra[31:27]} + round_func(rnd, rb, rc, rd) + re
                 + round_const(rnd) + w_cur;

  assign digest.valid       = out_busy;
  assign digest.digest_word = obuf[oidx];
  assign digest.word_index  = oidx;
  assign digest.last_word   = (oidx == INDEX_W'(DIGEST_WORDS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      byte_count <= '0;
      rnd        <= '0;
      ld         <= '0;
      pw         <= '0;
      fin        <= 1'b0;
      padding    <= 1'b0;
      pad_two    <= 1'b0;
      second     <= 1'b0;
      out_busy   <= 1'b0;
      oidx       <= '0;
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        chain[i] <= init_chain(INDEX_W'(i));
      end
    end else begin
      if (digest.valid && digest.ready) begin
        if (oidx == INDEX_W'(DIGEST_WORDS - 1)) begin
          out_busy <= 1'b0;
          oidx     <= '0;
        end else begin
          oidx <= oidx + 1'b1;
        end
      end

      case (state)
        IDLE: begin
          if (msg_fire) begin
            if (msg.byte_present) begin
              case (pos[1:0])
                2'd0:    acc[23:16] <= msg.data_byte;
                2'd1:    acc[15:8]  <= msg.data_byte;
                2'd2:    acc[7:0]   <= msg.data_byte;
                default: acc        <= acc;
              endcase
              byte_count <= byte_count + 1'b1;
              if (pos == 6'd63) begin
                fin   <= msg.end_of_message;
                ld    <= '0;
                state <= LOAD;
              end else if (msg.end_of_message) begin
                state <= PAD_HEAD;
              end
            end else if (msg.end_of_message) begin
              state <= PAD_HEAD;
            end
          end
        end

        LOAD: begin
          if (ld == 5'd0) begin
            ra <= chain[0];
            rb <= chain[1];
            rc <= chain[2];
            rd <= chain[3];
            re <= chain[4];
          end else begin
            for (int i = 0; i < 15; i++) begin
              win[i] <= win[i+1];
            end
            win[15] <= mem_rdata;
          end
          if (ld == 5'd16) begin
            rnd   <= '0;
            state <= ROUND;
          end else begin
            ld <= ld + 1'b1;
          end
        end

        ROUND: begin
          for (int i = 0; i < 15; i++) begin
            win[i] <= win[i+1];
          end
          win[15] <= w_cur;
          re <= rd;
          rd <= rc;
          rc <= {rb[1:0], rb[31:2]};
          rb <= ra;
          ra <= t_sum;
          if (rnd == 7'(ROUNDS - 1)) begin
            rnd   <= '0;
            state <= ADD;
          end else begin
            rnd <= rnd + 1'b1;
          end
        end

        ADD: begin
          chain[0] <= chain[0] + ra;
          chain[1] <= chain[1] + rb;
          chain[2] <= chain[2] + rc;
          chain[3] <= chain[3] + rd;
          chain[4] <= chain[4] + re;
          if (padding && len_block) begin
            state <= DONE;
          end else if (padding) begin
            second <= 1'b1;
            pw     <= '0;
            state  <= PAD_FILL;
          end else if (fin) begin
            fin   <= 1'b0;
            state <= PAD_HEAD;
          end else begin
            state <= IDLE;
          end
        end

        PAD_HEAD: begin
          padding <= 1'b1;
          pad_two <= (pos >= 6'd56);
          second  <= 1'b0;
          pw      <= pos[5:2] + 1'b1;
          if (pos[5:2] == 4'd15) begin
            ld    <= '0;
            state <= LOAD;
          end else begin
            state <= PAD_FILL;
          end
        end

        PAD_FILL: begin
          pw <= pw + 1'b1;
          if (pw == 4'd15) begin
            ld    <= '0;
            state <= LOAD;
          end
        end

        DONE: begin
          if (!out_busy) begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
              obuf[i]  <= chain[i];
              chain[i] <= init_chain(INDEX_W'(i));
            end
            out_busy   <= 1'b1;
            oidx       <= '0;
            byte_count <= '0;
            padding    <= 1'b0;
            pad_two    <= 1'b0;
            second     <= 1'b0;
            state      <= IDLE;
          end
        end

        default: state <= IDLE;
      endcase
    end
  end

endmodule
